@@ hw/rtl/wmmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wmmf_pkg
// Types, constants and helpers shared by the 3x3 median / mean window filter.
// ----------------------------------------------------------------------------
package wmmf_pkg;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned CFG_W    = 11;
	localparam int unsigned SUM_W    = 12;
	localparam int unsigned RECIP_W  = 13;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;
	localparam int unsigned MEAN_SHIFT = 16;

	// floor(sum / 9) == (sum * 7282) >> 16 for every sum of nine 8-bit values
	localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] pix9_t;
	typedef logic [5:0][PIX_W-1:0] wcols_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [3:0] win_idx_t;
	typedef logic [0:0] cfg_idx_t;

	localparam cfg_idx_t REG_PADDED_WIDTH = 1'b0;
	localparam cfg_idx_t REG_FILTER_MODE  = 1'b1;

	typedef enum logic {
		MODE_MEDIAN = 1'b0,
		MODE_MEAN   = 1'b1
	} filter_mode_t;

	localparam logic [CFG_W-1:0] PW_RESET = 11'd1024;
	localparam filter_mode_t MODE_RESET   = MODE_MEAN;

	localparam logic [1:0] ROW_FULL = 2'd2;

	// compare-exchange: smaller value to lo, larger to hi
	function automatic pix9_t cx(pix9_t p, win_idx_t lo, win_idx_t hi);
		pix_t a;
		pix_t b;
		pix9_t r;
		a = p[lo];
		b = p[hi];
		r = p;
		if (a > b) begin
			r[lo] = b;
			r[hi] = a;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/wmmf_line_buf.sv @@
// ----------------------------------------------------------------------------
// wmmf_line_buf
// Two line stores holding the rows above the current one, with write-back
// in the cycle after the read and a bypass for back-to-back same-column reads.
// ----------------------------------------------------------------------------
module wmmf_line_buf #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
	input  wmmf_pkg::pix_t                px,
	output wmmf_pkg::pix_t                top,
	output wmmf_pkg::pix_t                mid
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	wmmf_pkg::pix_t older_mem [MAX_WIDTH];
	wmmf_pkg::pix_t recent_mem [MAX_WIDTH];

	wmmf_pkg::pix_t older_rd_q;
	wmmf_pkg::pix_t recent_rd_q;
	wmmf_pkg::pix_t px_q;
	wmmf_pkg::pix_t byp_top_q;
	wmmf_pkg::pix_t byp_mid_q;
	logic [CW-1:0]  col_q;
	logic           wr_pend_q;
	logic           byp_q;

	assign top = byp_q ? byp_top_q : older_rd_q;
	assign mid = byp_q ? byp_mid_q : recent_rd_q;

	always_ff @(posedge clk) begin
		if (wr_pend_q) begin
			older_mem[col_q]  <= mid;
			recent_mem[col_q] <= px_q;
		end
		if (rd_en) begin
			older_rd_q  <= older_mem[rd_col];
			recent_rd_q <= recent_mem[rd_col];
			col_q       <= rd_col;
			px_q        <= px;
			byp_top_q   <= mid;
			byp_mid_q   <= px_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
			byp_q     <= 1'b0;
		end else begin
			wr_pend_q <= rd_en;
			if (rd_en) begin
				// previous transaction's write lands on this edge
				byp_q <= wr_pend_q && (rd_col == col_q);
			end
		end
	end

endmodule

@@ hw/rtl/wmmf_kernel.sv @@
// ----------------------------------------------------------------------------
// wmmf_kernel
// Median of nine by a compare-exchange network, and the sum of the window.
// ----------------------------------------------------------------------------
module wmmf_kernel (
	input  wmmf_pkg::pix9_t win,
	output wmmf_pkg::pix_t  median,
	output wmmf_pkg::sum_t  sum
);

	wmmf_pkg::pix9_t p;

	always_comb begin
		p = win;
		p = wmmf_pkg::cx(p, 4'd1, 4'd2);
		p = wmmf_pkg::cx(p, 4'd4, 4'd5);
		p = wmmf_pkg::cx(p, 4'd7, 4'd8);
		p = wmmf_pkg::cx(p, 4'd0, 4'd1);
		p = wmmf_pkg::cx(p, 4'd3, 4'd4);
		p = wmmf_pkg::cx(p, 4'd6, 4'd7);
		p = wmmf_pkg::cx(p, 4'd1, 4'd2);
		p = wmmf_pkg::cx(p, 4'd4, 4'd5);
		p = wmmf_pkg::cx(p, 4'd7, 4'd8);
		p = wmmf_pkg::cx(p, 4'd0, 4'd3);
		p = wmmf_pkg::cx(p, 4'd5, 4'd8);
		p = wmmf_pkg::cx(p, 4'd4, 4'd7);
		p = wmmf_pkg::cx(p, 4'd3, 4'd6);
		p = wmmf_pkg::cx(p, 4'd1, 4'd4);
		p = wmmf_pkg::cx(p, 4'd2, 4'd5);
		p = wmmf_pkg::cx(p, 4'd4, 4'd7);
		p = wmmf_pkg::cx(p, 4'd4, 4'd2);
		p = wmmf_pkg::cx(p, 4'd6, 4'd4);
		p = wmmf_pkg::cx(p, 4'd4, 4'd2);
	end

	assign median = p[4];

	assign sum = ((wmmf_pkg::sum_t'(win[0]) + wmmf_pkg::sum_t'(win[1]))
	            + (wmmf_pkg::sum_t'(win[2]) + wmmf_pkg::sum_t'(win[3])))
	           + ((wmmf_pkg::sum_t'(win[4]) + wmmf_pkg::sum_t'(win[5]))
	            + (wmmf_pkg::sum_t'(win[6]) + wmmf_pkg::sum_t'(win[7])))
	           + wmmf_pkg::sum_t'(win[8]);

endmodule

@@ hw/rtl/window3x3_median_mean_filter.sv @@
// ----------------------------------------------------------------------------
// window3x3_median_mean_filter
// 3x3 median or truncated-mean filter over a raster stream of padded pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one 8-bit pixel per transaction in raster order, s_tuser
//   marks the first pixel of a frame. Each pixel from row 2 and column 2
//   onward yields one result on m_tdata for the window centre; m_tlast marks
//   the last result of a row. Pixels of the first two rows and columns give
//   no result.
//   cfg_we / cfg_index / cfg_data write padded_width (index 0, clamped to
//   3..MAX_WIDTH) and filter_mode (index 1: 0 median, 1 mean) while idle.
//   Throughput is one pixel per clock while m_tready is high. A result is
//   registered in stage 1 by the line-store read on the transaction edge,
//   then in stage 2 after window and sort/sum, then divided by nine into the
//   output register. The line-store RAM read sets the first stage.
//   Reset clears position, window and stage valids and restores
//   padded_width 1024 and mean mode; line stores are not cleared.
//   When m_tready is low the output holds; the two inner stages keep
//   accepting until they are full, then s_tready drops.
// ----------------------------------------------------------------------------
module window3x3_median_mean_filter #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	input  logic [0:0]  s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] filtered
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = (CW + 1 > wmmf_pkg::CFG_W) ? CW + 1 : wmmf_pkg::CFG_W;

	// configuration
	logic [wmmf_pkg::CFG_W-1:0] pw_q;
	wmmf_pkg::filter_mode_t     mode_q;

	// position state
	logic [CW-1:0] col_q;
	logic [1:0]    row_q;
	wmmf_pkg::wcols_t wcol_q;

	// stage 1
	logic           vld_s1;
	wmmf_pkg::pix_t px_s1;
	logic           fs_s1;
	logic           prod_s1;
	logic           rend_s1;

	// stage 2
	logic           vld_s2;
	wmmf_pkg::pix_t med_s2;
	wmmf_pkg::sum_t sum_s2;
	logic           rend_s2;

	// output register
	logic           out_vld_q;
	wmmf_pkg::pix_t out_pix_q;
	logic           out_last_q;

	logic acc;
	logic out_ld;
	logic s2_free;
	logic s1_go;

	logic [WW-1:0] wcl;
	logic [WW-1:0] pw_ext;
	logic [CW-1:0] colb;
	logic [1:0]    rowb;
	logic          wrap0;
	logic [CW-1:0] col;
	logic [1:0]    rowc;
	logic [WW-1:0] col_inc;
	logic          last;
	logic          prod;

	wmmf_pkg::pix_t   top;
	wmmf_pkg::pix_t   mid;
	wmmf_pkg::wcols_t wbase;
	wmmf_pkg::pix9_t  win;
	wmmf_pkg::pix_t   median;
	wmmf_pkg::sum_t   sum;

	logic [wmmf_pkg::PROD_W-1:0] prod_mean;
	wmmf_pkg::pix_t              mean;

	// handshake and stage advance
	assign out_ld   = vld_s2 && (!out_vld_q || m_tready);
	assign s2_free  = !vld_s2 || out_ld;
	assign s1_go    = vld_s1 && s2_free;
	assign s_tready = !vld_s1 || s2_free;
	assign acc      = s_tvalid && s_tready;

	// position of the incoming pixel
	always_comb begin
		pw_ext = WW'(pw_q);
		if (pw_ext < WW'(3)) begin
			wcl = WW'(3);
		end else if (pw_ext > WW'(MAX_WIDTH)) begin
			wcl = WW'(MAX_WIDTH);
		end else begin
			wcl = pw_ext;
		end
		colb  = s_tuser[0] ? '0 : col_q;
		rowb  = s_tuser[0] ? 2'd0 : row_q;
		wrap0 = WW'(colb) >= wcl;
		col   = wrap0 ? '0 : colb;
		if (wrap0 && (rowb != wmmf_pkg::ROW_FULL)) begin
			rowc = rowb + 2'd1;
		end else begin
			rowc = rowb;
		end
		col_inc = WW'(col) + WW'(1);
		last    = col_inc >= wcl;
		prod    = (rowc == wmmf_pkg::ROW_FULL) && (col >= CW'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q   <= wmmf_pkg::PW_RESET;
			mode_q <= wmmf_pkg::MODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmmf_pkg::REG_PADDED_WIDTH: pw_q <= cfg_data;
				wmmf_pkg::REG_FILTER_MODE: mode_q <= wmmf_pkg::filter_mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
		end else if (acc) begin
			if (last) begin
				col_q <= '0;
				row_q <= (rowc != wmmf_pkg::ROW_FULL) ? rowc + 2'd1 : rowc;
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= rowc;
			end
		end
	end

	wmmf_line_buf #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (acc),
		.rd_col (col),
		.px     (s_tdata),
		.top    (top),
		.mid    (mid)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= s_tdata;
			fs_s1   <= s_tuser[0];
			prod_s1 <= prod;
			rend_s1 <= last;
		end
	end

	// window assembly
	always_comb begin
		wbase  = fs_s1 ? '0 : wcol_q;
		win[0] = wbase[0];
		win[1] = wbase[3];
		win[2] = top;
		win[3] = wbase[1];
		win[4] = wbase[4];
		win[5] = mid;
		win[6] = wbase[2];
		win[7] = wbase[5];
		win[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcol_q <= '0;
		end else if (s1_go) begin
			wcol_q[0] <= wbase[3];
			wcol_q[1] <= wbase[4];
			wcol_q[2] <= wbase[5];
			wcol_q[3] <= top;
			wcol_q[4] <= mid;
			wcol_q[5] <= px_s1;
		end
	end

	wmmf_kernel u_kernel (
		.win    (win),
		.median (median),
		.sum    (sum)
	);

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_go) begin
			vld_s2 <= prod_s1;
		end else if (out_ld) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			med_s2  <= median;
			sum_s2  <= sum;
			rend_s2 <= rend_s1;
		end
	end

	// divide by nine
	assign prod_mean = wmmf_pkg::PROD_W'(sum_s2) * wmmf_pkg::PROD_W'(wmmf_pkg::MEAN_RECIP);
	assign mean      = prod_mean[wmmf_pkg::MEAN_SHIFT +: wmmf_pkg::PIX_W];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_ld) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			out_pix_q  <= (mode_q == wmmf_pkg::MODE_MEAN) ? mean : med_s2;
			out_last_q <= rend_s2;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

	// checks
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd3)
		else $error("row position beyond saturation");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && out_vld_q))
		else $error("input stalled with a free stage");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser[0]) |=> (row_q == 2'd0))
		else $error("frame start did not reset row position");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_s2))
		else $error("result without a filled second stage");

endmodule
